/* hw/rtl/paired_length_histogram_unit_assert.svh */
// Assertion macros used by the back end of the histogram unit.
`ifndef PAIRED_LENGTH_HISTOGRAM_UNIT_ASSERT_SVH
`define PAIRED_LENGTH_HISTOGRAM_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/plh_pkg.sv */
`default_nettype none

package plh_pkg;

    localparam int BIN_COUNT   = 1024;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_W       = $clog2(BIN_COUNT);
    localparam int LEN_W       = 16;
    localparam int IDX_W       = 10;
    localparam int ACTION_W    = 2;
    localparam int OUT_COUNT_W = 32;
    localparam int TOTAL_W     = 40;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0]    TOP_BIN   = LEN_W'(BIN_COUNT - 1);
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX = '1;
    localparam logic [ACTION_W-1:0] ACT_SINGLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PAIR   = 2'd1;

    typedef logic [BIN_W-1:0]       bin_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        KIND_SINGLE,
        KIND_PAIR,
        KIND_QUERY
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        bin_t              bin_first;
        bin_t              bin_second;
        logic [LEN_W-1:0]  item_longest;
        logic              clamped;
    } job_t;

    typedef struct packed {
        logic clearing;
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    function automatic logic [OUT_COUNT_W-1:0] report(input count_t c);
        logic [63:0] w;
        w = 64'(c);
        if (w > 64'hFFFF_FFFF)
        begin
            return '1;
        end
        return w[OUT_COUNT_W-1:0];
    endfunction

    function automatic logic is_over(input logic [LEN_W-1:0] v);
        return v > TOP_BIN;
    endfunction

    function automatic bin_t to_bin(input logic [LEN_W-1:0] v);
        return is_over(v) ? TOP_BIN[BIN_W-1:0] : v[BIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/plh_item_if.sv */
`default_nettype none

interface plh_item_if import plh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [LEN_W-1:0]    length_first;
    logic [LEN_W-1:0]    length_second;
    logic [IDX_W-1:0]    bin_index;

    modport source (output valid, action, length_first, length_second, bin_index,
                    input ready);
    modport sink (input valid, action, length_first, length_second, bin_index,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/plh_result_if.sv */
`default_nettype none

interface plh_result_if import plh_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OUT_COUNT_W-1:0] first_bin_count;
    logic [OUT_COUNT_W-1:0] second_bin_count;
    logic [TOTAL_W-1:0]     total_reads;
    logic [LEN_W-1:0]       longest_length;
    logic                   clamped;

    modport source (output valid, first_bin_count, second_bin_count, total_reads,
                    longest_length, clamped, input ready);
    modport sink (input valid, first_bin_count, second_bin_count, total_reads,
                  longest_length, clamped, output ready);
endinterface

`default_nettype wire

/* hw/rtl/paired_length_histogram_unit.sv */
`default_nettype none

// Paired read-length histogram. Each accepted word is a single read, a read pair or a
// query, and each gives exactly one result word with the bin counts after the update,
// the saturating read total and the longest length seen. The back end takes a new word
// only when it is through with the last one: it reads both histogram memories together
// (registered read) and writes the incremented counts in the next cycle. A front
// register and a two-entry queue decouple input acceptance from that loop, and a result
// register holds each result until it is taken; while a result waits the back end reads
// no new word, and it reads the next one, if one is queued, in the cycle in which the
// waiting result is taken. After reset a clearing pass zeroes all BIN_COUNT (1024)
// entries of both memories, during which no word is accepted.

module paired_length_histogram_unit import plh_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    plh_item_if.sink     items,
    plh_result_if.source results
);

    status_t status;
    logic    push;
    job_t    push_job;
    logic    full;
    logic    pop;
    job_t    head;
    logic    empty;

    plh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .status   (status),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    plh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    plh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .empty   (empty),
        .head    (head),
        .pop     (pop),
        .status  (status),
        .results (results)
    );

endmodule

`default_nettype wire

/* hw/rtl/plh_ram.sv */
`default_nettype none

module plh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/plh_front.sv */
`default_nettype none

module plh_front import plh_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    plh_item_if.sink        items,
    input  status_t         status,
    input  logic            full,
    output logic            push,
    output job_t            push_job
);

    logic job_valid_reg;
    logic job_valid_next;
    job_t job_reg;
    job_t job_next;
    logic accept;

    assign items.ready = !status.clearing && (!job_valid_reg || !full);
    assign accept      = items.valid && items.ready;
    assign push        = job_valid_reg && !full;
    assign push_job    = job_reg;

    always_comb
    begin
        job_next = job_reg;
        unique case (items.action)
            ACT_SINGLE:
            begin
                job_next.kind         = KIND_SINGLE;
                job_next.bin_first    = to_bin(items.length_first);
                job_next.bin_second   = to_bin(items.length_first);
                job_next.item_longest = items.length_first;
                job_next.clamped      = is_over(items.length_first);
            end
            ACT_PAIR:
            begin
                job_next.kind         = KIND_PAIR;
                job_next.bin_first    = to_bin(items.length_first);
                job_next.bin_second   = to_bin(items.length_second);
                job_next.item_longest = (items.length_first > items.length_second) ?
                                        items.length_first : items.length_second;
                job_next.clamped      = is_over(items.length_first) ||
                                        is_over(items.length_second);
            end
            default:
            begin
                job_next.kind         = KIND_QUERY;
                job_next.bin_first    = to_bin(LEN_W'(items.bin_index));
                job_next.bin_second   = to_bin(LEN_W'(items.bin_index));
                job_next.item_longest = '0;
                job_next.clamped      = is_over(LEN_W'(items.bin_index));
            end
        endcase
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (accept)
        begin
            job_valid_next = 1'b1;
        end
        else if (push)
        begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/plh_queue.sv */
`default_nettype none

module plh_queue import plh_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    job_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/plh_back.sv */
`default_nettype none
`include "paired_length_histogram_unit_assert.svh"

module plh_back import plh_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         empty,
    input  job_t         head,
    output logic         pop,
    output status_t      status,
    plh_result_if.source results
);

    state_t                 state_reg;
    state_t                 state_next;
    bin_t                   clr_cnt_reg;
    bin_t                   clr_cnt_next;
    job_t                   job_reg;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic [OUT_COUNT_W-1:0] res_first_reg;
    logic [OUT_COUNT_W-1:0] res_second_reg;
    logic                   res_clamped_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;
    logic [LEN_W-1:0]       longest_reg;
    logic [LEN_W-1:0]       longest_next;

    logic   out_free;
    logic   we_first;
    logic   we_second;
    bin_t   waddr_first;
    bin_t   waddr_second;
    count_t wdata_first;
    count_t wdata_second;
    count_t rd_first;
    count_t rd_second;
    count_t inc_first;
    count_t inc_second;
    logic [OUT_COUNT_W-1:0] rep_first;
    logic [OUT_COUNT_W-1:0] rep_second;
    logic [1:0]         add_n;

    plh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BIN_COUNT)) u_first_ram (
        .clk   (clk),
        .we    (we_first),
        .waddr (waddr_first),
        .wdata (wdata_first),
        .raddr (head.bin_first),
        .rdata (rd_first)
    );

    plh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BIN_COUNT)) u_second_ram (
        .clk   (clk),
        .we    (we_second),
        .waddr (waddr_second),
        .wdata (wdata_second),
        .raddr (head.bin_second),
        .rdata (rd_second)
    );

    assign out_free   = !res_valid_reg || results.ready;
    assign inc_first  = (rd_first == '1) ? rd_first : rd_first + 1'b1;
    assign inc_second = (rd_second == '1) ? rd_second : rd_second + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == BIN_W'(BIN_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!empty && out_free)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop             = 1'b0;
        status.clearing = 1'b0;
        we_first        = 1'b0;
        we_second       = 1'b0;
        waddr_first     = job_reg.bin_first;
        waddr_second    = job_reg.bin_second;
        wdata_first     = inc_first;
        wdata_second    = inc_second;
        unique case (state_reg)
            ST_CLEAR:
            begin
                status.clearing = 1'b1;
                we_first        = 1'b1;
                we_second       = 1'b1;
                waddr_first     = clr_cnt_reg;
                waddr_second    = clr_cnt_reg;
                wdata_first     = '0;
                wdata_second    = '0;
            end
            ST_IDLE:
            begin
                pop = !empty && out_free;
            end
            ST_UPDATE:
            begin
                we_first  = job_reg.kind != KIND_QUERY;
                we_second = job_reg.kind == KIND_PAIR;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        clr_cnt_next   = (state_reg == ST_CLEAR) ? BIN_W'(clr_cnt_reg + 1'b1) : clr_cnt_reg;
        rep_first      = report((job_reg.kind != KIND_QUERY) ? inc_first : rd_first);
        rep_second     = report((job_reg.kind == KIND_PAIR) ? inc_second : rd_second);
        add_n          = (job_reg.kind == KIND_PAIR) ? 2'd2 :
                         (job_reg.kind == KIND_SINGLE) ? 2'd1 : 2'd0;
        total_next     = total_reg;
        longest_next   = longest_reg;
        res_valid_next = results.ready ? 1'b0 : res_valid_reg;
        if (state_reg == ST_UPDATE)
        begin
            res_valid_next = 1'b1;
            if (total_reg > TOTAL_MAX - TOTAL_W'(add_n))
            begin
                total_next = TOTAL_MAX;
            end
            else
            begin
                total_next = total_reg + TOTAL_W'(add_n);
            end
            if (job_reg.item_longest > longest_reg)
            begin
                longest_next = job_reg.item_longest;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            total_reg     <= '0;
            longest_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_valid_reg <= res_valid_next;
            total_reg     <= total_next;
            longest_reg   <= longest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (state_reg == ST_UPDATE)
        begin
            res_first_reg   <= rep_first;
            res_second_reg  <= rep_second;
            res_clamped_reg <= job_reg.clamped;
        end
    end

    assign results.valid            = res_valid_reg;
    assign results.first_bin_count  = res_first_reg;
    assign results.second_bin_count = res_second_reg;
    assign results.total_reads      = total_reg;
    assign results.longest_length   = longest_reg;
    assign results.clamped          = res_clamped_reg;

    `PLH_ASSERT_SAME(a_no_pop_in_clear, clk, rst_n, state_reg == ST_CLEAR, !pop,
        "queue popped during the clearing pass")
    `PLH_ASSERT_SAME(a_pop_needs_free_out, clk, rst_n, pop,
        !res_valid_reg || results.ready, "pop would overwrite a pending result")
    `PLH_ASSERT_NEXT(a_update_gives_result, clk, rst_n, state_reg == ST_UPDATE,
        res_valid_reg, "update cycle did not present a result")

endmodule

`default_nettype wire

/* test/tb_paired_length_histogram_unit.sv */
`timescale 1ns / 100ps

module tb_paired_length_histogram_unit;
    import plh_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_PER_PACE = 190;

    typedef enum int {
        PACE_FULL,
        PACE_SLOW_SEND,
        PACE_SLOW_TAKE,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] first_count;
        logic [OUT_COUNT_W-1:0] second_count;
        logic [TOTAL_W-1:0]     total;
        logic [LEN_W-1:0]       longest;
        logic                   clamped;
    } bin_report_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LEN_W-1:0]    length_first;
        logic [LEN_W-1:0]    length_second;
        logic [IDX_W-1:0]    bin_index;
        logic                typed;
        bin_report_t         want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    plh_item_if   items_ch();
    plh_result_if results_ch();

    paired_length_histogram_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    count_t             first_bins [BIN_COUNT];
    count_t             second_bins [BIN_COUNT];
    logic [TOTAL_W-1:0] reads_counted;
    logic [LEN_W-1:0]   longest_read;

    bin_report_t pending_reports [$];
    int          mismatches;
    pace_t       pace;
    bit          hold_request;
    int          hold_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #3_000_000;
        $display("tb_paired_length_histogram_unit failed");
        $finish;
    end

    task automatic note_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatches < 40)
        begin
            $display("mismatch %s: got %0h, want %0h", field, got, want);
        end
        mismatches++;
    endtask

    function automatic logic clip_bin(input logic [LEN_W-1:0] v, output bin_t b);
        if (v > TOP_BIN)
        begin
            b = bin_t'(BIN_COUNT - 1);
            return 1'b1;
        end
        b = bin_t'(v);
        return 1'b0;
    endfunction

    function automatic count_t bumped(input count_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic void add_reads(input int unsigned n);
        if (reads_counted > TOTAL_MAX - TOTAL_W'(n))
        begin
            reads_counted = TOTAL_MAX;
        end
        else
        begin
            reads_counted = reads_counted + TOTAL_W'(n);
        end
    endfunction

    function automatic logic [OUT_COUNT_W-1:0] out_count(input count_t c);
        logic [63:0] wide;
        wide = 64'(c);
        return (wide > 64'hFFFF_FFFF) ? '1 : wide[OUT_COUNT_W-1:0];
    endfunction

    function automatic bin_report_t tally_word(input stim_row_t w);
        bin_report_t r;
        bin_t        b1;
        bin_t        b2;
        logic        over;
        over = 1'b0;
        if (w.action == ACT_SINGLE)
        begin
            over = clip_bin(w.length_first, b1);
            b2 = b1;
            first_bins[b1] = bumped(first_bins[b1]);
            add_reads(1);
            if (w.length_first > longest_read)
            begin
                longest_read = w.length_first;
            end
        end
        else if (w.action == ACT_PAIR)
        begin
            over = clip_bin(w.length_first, b1);
            over = clip_bin(w.length_second, b2) | over;
            first_bins[b1] = bumped(first_bins[b1]);
            second_bins[b2] = bumped(second_bins[b2]);
            add_reads(2);
            if (w.length_first > longest_read)
            begin
                longest_read = w.length_first;
            end
            if (w.length_second > longest_read)
            begin
                longest_read = w.length_second;
            end
        end
        else
        begin
            over = clip_bin(LEN_W'(w.bin_index), b1);
            b2 = b1;
        end
        r.first_count  = out_count(first_bins[b1]);
        r.second_count = out_count(second_bins[b2]);
        r.total        = reads_counted;
        r.longest      = longest_read;
        r.clamped      = over;
        return r;
    endfunction

    function automatic stim_row_t row(input logic [ACTION_W-1:0] action,
                                      input logic [LEN_W-1:0] len1,
                                      input logic [LEN_W-1:0] len2,
                                      input logic [IDX_W-1:0] idx,
                                      input logic typed,
                                      input bin_report_t want);
        stim_row_t s;
        s.action        = action;
        s.length_first  = len1;
        s.length_second = len2;
        s.bin_index     = idx;
        s.typed         = typed;
        s.want          = want;
        return s;
    endfunction

    function automatic bin_report_t rep(input int unsigned f, input int unsigned s,
                                        input int unsigned total,
                                        input int unsigned longest, input logic c);
        bin_report_t r;
        r.first_count  = f;
        r.second_count = s;
        r.total        = TOTAL_W'(total);
        r.longest      = LEN_W'(longest);
        r.clamped      = c;
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            return LEN_W'($urandom_range(0, 7));
        end
        if (pick < 8)
        begin
            return LEN_W'($urandom_range(0, 1200));
        end
        return LEN_W'($urandom);
    endfunction

    function automatic stim_row_t random_row();
        int unsigned         pick;
        logic [ACTION_W-1:0] action;
        logic [IDX_W-1:0]    idx;
        pick = $urandom_range(0, 19);
        if (pick < 8)
        begin
            action = ACT_SINGLE;
        end
        else if (pick < 16)
        begin
            action = ACT_PAIR;
        end
        else if (pick < 19)
        begin
            action = ACT_QUERY;
        end
        else
        begin
            action = ACT_SPARE;
        end
        idx = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom);
        return row(action, random_length(), random_length(), idx, 1'b0, '0);
    endfunction

    function automatic bit send_gap();
        if (pace == PACE_SLOW_SEND)
        begin
            return $urandom_range(0, 99) < 80;
        end
        if (pace == PACE_BOTH)
        begin
            return $urandom_range(0, 99) < 30;
        end
        return 1'b0;
    endfunction

    function automatic bit take_now();
        if (pace == PACE_SLOW_TAKE)
        begin
            return $urandom_range(0, 99) >= 80;
        end
        if (pace == PACE_BOTH)
        begin
            return $urandom_range(0, 99) >= 30;
        end
        return 1'b1;
    endfunction

    task automatic send_word(input stim_row_t w);
        bin_report_t want;
        while (send_gap())
        begin
            items_ch.valid <= 1'b0;
            @(posedge clk);
        end
        items_ch.valid         <= 1'b1;
        items_ch.action        <= w.action;
        items_ch.length_first  <= w.length_first;
        items_ch.length_second <= w.length_second;
        items_ch.bin_index     <= w.bin_index;
        @(posedge clk);
        while (!items_ch.ready)
        begin
            @(posedge clk);
        end
        want = tally_word(w);
        if (w.typed)
        begin
            want = w.want;
        end
        pending_reports.push_back(want);
    endtask

    initial
    begin
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_ch.ready <= 1'b0;
            end
            else
            begin
                results_ch.ready <= take_now();
            end
        end
    end

    always @(posedge clk)
    begin
        bin_report_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                note_mismatch("result with nothing pending", 64'(results_ch.total_reads),
                              64'd0);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (results_ch.first_bin_count !== want.first_count)
                begin
                    note_mismatch("first_bin_count", 64'(results_ch.first_bin_count),
                                  64'(want.first_count));
                end
                if (results_ch.second_bin_count !== want.second_count)
                begin
                    note_mismatch("second_bin_count", 64'(results_ch.second_bin_count),
                                  64'(want.second_count));
                end
                if (results_ch.total_reads !== want.total)
                begin
                    note_mismatch("total_reads", 64'(results_ch.total_reads),
                                  64'(want.total));
                end
                if (results_ch.longest_length !== want.longest)
                begin
                    note_mismatch("longest_length", 64'(results_ch.longest_length),
                                  64'(want.longest));
                end
                if (results_ch.clamped !== want.clamped)
                begin
                    note_mismatch("clamped", 64'(results_ch.clamped), 64'(want.clamped));
                end
            end
        end
    end

    initial
    begin
        stim_row_t plan [$];
        int        n;
        int        p;
        mismatches   = 0;
        pace         = PACE_FULL;
        hold_request = 1'b0;
        hold_left    = 0;
        reads_counted = '0;
        longest_read  = '0;
        for (n = 0; n < BIN_COUNT; n++)
        begin
            first_bins[n]  = '0;
            second_bins[n] = '0;
        end
        rst_n                  <= 1'b0;
        items_ch.valid         <= 1'b0;
        items_ch.action        <= ACT_SINGLE;
        items_ch.length_first  <= '0;
        items_ch.length_second <= '0;
        items_ch.bin_index     <= '0;

        plan.push_back(row(ACT_QUERY, 0, 0, 0, 1'b1, rep(0, 0, 0, 0, 1'b0)));
        plan.push_back(row(ACT_QUERY, 0, 0, 1023, 1'b1, rep(0, 0, 0, 0, 1'b0)));
        plan.push_back(row(ACT_SINGLE, 0, 0, 0, 1'b1, rep(1, 0, 1, 0, 1'b0)));
        plan.push_back(row(ACT_SINGLE, 16'hFFFF, 0, 0, 1'b1, rep(1, 0, 2, 65535, 1'b1)));
        plan.push_back(row(ACT_PAIR, 1023, 1023, 0, 1'b1, rep(2, 1, 4, 65535, 1'b0)));
        plan.push_back(row(ACT_PAIR, 1024, 0, 0, 1'b1, rep(3, 1, 6, 65535, 1'b1)));
        plan.push_back(row(ACT_PAIR, 0, 16'hFFFF, 0, 1'b1, rep(2, 2, 8, 65535, 1'b1)));
        plan.push_back(row(ACT_SPARE, 0, 0, 0, 1'b1, rep(2, 1, 8, 65535, 1'b0)));
        plan.push_back(row(ACT_SINGLE, 1023, 0, 0, 1'b1, rep(4, 2, 9, 65535, 1'b0)));
        plan.push_back(row(ACT_PAIR, 16'hAAAA, 16'h5555, 0, 1'b0, '0));
        plan.push_back(row(ACT_SINGLE, 16'h5555, 16'hAAAA, 10'h2AA, 1'b0, '0));
        plan.push_back(row(ACT_QUERY, 0, 0, 10'h2AA, 1'b0, '0));
        plan.push_back(row(ACT_QUERY, 0, 0, 10'h155, 1'b0, '0));
        plan.push_back(row(ACT_PAIR, 512, 511, 0, 1'b0, '0));
        plan.push_back(row(ACT_SINGLE, 1, 0, 0, 1'b0, '0));
        plan.push_back(row(ACT_QUERY, 0, 0, 1, 1'b0, '0));
        plan.push_back(row(ACT_SPARE, 0, 0, 1023, 1'b0, '0));
        plan.push_back(row(ACT_PAIR, 3, 3, 0, 1'b0, '0));
        plan.push_back(row(ACT_PAIR, 3, 3, 0, 1'b0, '0));
        plan.push_back(row(ACT_PAIR, 3, 3, 0, 1'b0, '0));
        plan.push_back(row(ACT_SINGLE, 3, 0, 0, 1'b0, '0));
        plan.push_back(row(ACT_QUERY, 0, 0, 3, 1'b0, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < plan.size(); n++)
        begin
            send_word(plan[n]);
        end

        for (p = PACE_FULL; p <= PACE_BOTH; p++)
        begin
            pace = pace_t'(p);
            if (pace == PACE_FULL)
            begin
                hold_request = 1'b1;
            end
            for (n = 0; n < RANDOM_PER_PACE; n++)
            begin
                send_word(random_row());
            end
        end
        items_ch.valid <= 1'b0;

        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("tb_paired_length_histogram_unit passed");
        end
        else
        begin
            $display("tb_paired_length_histogram_unit failed");
        end
        $finish;
    end

endmodule
